>>> design/spq_pkg.sv
package spq_pkg;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

>>> design/spq_if.sv
interface spq_req_if #(
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32
);
	logic                            valid;
	logic                            ready;
	logic [1:0]                      operation;
	logic signed [PRIORITY_BITS-1:0] new_priority;
	logic [PAYLOAD_BITS-1:0]         new_payload;

	modport source (output valid, output operation, output new_priority,
		output new_payload, input ready);
	modport sink (input valid, input operation, input new_priority,
		input new_payload, output ready);
endinterface

interface spq_rsp_if #(
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int COUNT_BITS    = 4
);
	logic                            valid;
	logic                            ready;
	logic [1:0]                      status;
	logic signed [PRIORITY_BITS-1:0] head_priority;
	logic [PAYLOAD_BITS-1:0]         head_payload;
	logic [COUNT_BITS-1:0]           entry_count;

	modport source (output valid, output status, output head_priority,
		output head_payload, output entry_count, input ready);
	modport sink (input valid, input status, input head_priority,
		input head_payload, input entry_count, output ready);
endinterface

>>> design/sorted_priority_queue.sv
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one operation per cycle while results are taken; every cell compares and shifts at once.
// A request beat enters only when no result is held or the held result is
// taken in the same cycle; a stalled result stalls the request side.
// Reset clears the entry count and the result valid; slot contents are not
// cleared, and only slots below the count are ever read.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH         = 8,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                   count_q;
	logic                            rsp_valid_q;
	status_t                         status_q;
	logic signed [PRIORITY_BITS-1:0] head_prio_q;
	logic [PAYLOAD_BITS-1:0]         head_data_q;

	logic                            accept;
	cell_ctrl_t                      ctrl;
	status_t                         status_d;
	logic                            show_head;
	logic [CW-1:0]                   count_d;

	logic                            after_w [DEPTH];
	logic signed [PRIORITY_BITS-1:0] prio_w  [DEPTH];
	logic [PAYLOAD_BITS-1:0]         data_w  [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		ctrl      = '0;
		status_d  = ST_OK;
		show_head = 1'b0;
		count_d   = count_q;
		unique case (op_t'(req.operation))
			OP_ENQUEUE: begin
				if (count_q == CW'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					ctrl.enq = accept;
					count_d  = count_q + 1'b1;
				end
			end
			OP_DEQUEUE, OP_PEEK: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					show_head = 1'b1;
					if (op_t'(req.operation) == OP_DEQUEUE) begin
						ctrl.deq = accept;
						count_d  = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                            occ;
			logic                            l_after;
			logic signed [PRIORITY_BITS-1:0] l_prio;
			logic [PAYLOAD_BITS-1:0]         l_data;
			logic signed [PRIORITY_BITS-1:0] r_prio;
			logic [PAYLOAD_BITS-1:0]         r_data;

			assign occ = count_q > CW'(i);

			if (i == 0) begin : g_first
				assign l_after = 1'b0;
				assign l_prio  = '0;
				assign l_data  = '0;
			end else begin : g_mid
				assign l_after = after_w[i-1];
				assign l_prio  = prio_w[i-1];
				assign l_data  = data_w[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign r_prio = prio_w[i];
				assign r_data = data_w[i];
			end else begin : g_inner
				assign r_prio = prio_w[i+1];
				assign r_data = data_w[i+1];
			end

			spq_cell #(
				.PRIORITY_BITS (PRIORITY_BITS),
				.PAYLOAD_BITS  (PAYLOAD_BITS)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (occ),
				.new_prio   (req.new_priority),
				.new_data   (req.new_payload),
				.left_after (l_after),
				.left_prio  (l_prio),
				.left_data  (l_data),
				.right_prio (r_prio),
				.right_data (r_data),
				.after      (after_w[i]),
				.prio_q     (prio_w[i]),
				.data_q     (data_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			head_prio_q <= show_head ? prio_w[0] : '0;
			head_data_q <= show_head ? data_w[0] : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.head_priority = head_prio_q;
	assign rsp.head_payload  = head_data_q;
	assign rsp.entry_count   = count_q;

endmodule

>>> design/spq_cell.sv
module spq_cell import spq_pkg::*; #(
	parameter int PRIORITY_BITS = 16,
	parameter int PAYLOAD_BITS  = 32
) (
	input  logic                            clk,
	input  cell_ctrl_t                      ctrl,
	input  logic                            occupied,
	input  logic signed [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]         new_data,
	input  logic                            left_after,
	input  logic signed [PRIORITY_BITS-1:0] left_prio,
	input  logic [PAYLOAD_BITS-1:0]         left_data,
	input  logic signed [PRIORITY_BITS-1:0] right_prio,
	input  logic [PAYLOAD_BITS-1:0]         right_data,
	output logic                            after,
	output logic signed [PRIORITY_BITS-1:0] prio_q,
	output logic [PAYLOAD_BITS-1:0]         data_q
);

	assign after = !occupied || (new_prio < prio_q);

	always_ff @(posedge clk) begin
		if (ctrl.enq && after) begin
			// shift back behind the new entry, or take it here
			prio_q <= left_after ? left_prio : new_prio;
			data_q <= left_after ? left_data : new_data;
		end else if (ctrl.deq) begin
			prio_q <= right_prio;
			data_q <= right_data;
		end
	end

endmodule
